/* rtl/deq_pkg.sv */
`default_nettype none

package deq_pkg;

    // Geometry
    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int DATA_W      = 32;
    localparam int SUM_W       = 37;
    localparam int OCC_W       = 6;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP_FWD   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP_BWD   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic take;        // latch the accepted request
        logic decode;      // capture the single-result status
        logic push_wr;     // store value, move pointers, add to sum
        logic pop_rd;      // read the popped slot, move pointers
        logic dump_first;  // start a dump: read first slot, clear step
        logic dump_adv;    // read next dump slot, advance step
        logic ld_res;      // load a result without element
        logic ld_pop;      // load popped element, subtract from sum
        logic ld_dump;     // load dumped element
    } deq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_dump;
        logic full;
        logic empty;
        logic out_free;
        logic dump_end;
    } deq_stat_t;

endpackage

`default_nettype wire

/* rtl/deq_ram.sv */
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_W,
    parameter int DEPTH = deq_pkg::CAPACITY
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/deq_ctrl.sv */
`default_nettype none

module deq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire deq_pkg::deq_stat_t st,
    output deq_pkg::deq_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMD  = 5'b00010,
        S_RES  = 5'b00100,
        S_POP  = 5'b01000,
        S_DUMP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_CMD;
                end
            end
            S_CMD: begin
                cmd.decode = 1'b1;
                if (st.is_push && !st.full) begin
                    cmd.push_wr = 1'b1;
                    state_next  = S_RES;
                end else if (st.is_pop && !st.empty) begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP;
                end else if (st.is_dump && !st.empty) begin
                    cmd.dump_first = 1'b1;
                    state_next     = S_DUMP;
                end else begin
                    state_next = S_RES;
                end
            end
            S_RES: begin
                if (st.out_free) begin
                    cmd.ld_res = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP: begin
                if (st.out_free) begin
                    cmd.ld_pop = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (st.out_free) begin
                    cmd.ld_dump = 1'b1;
                    if (st.dump_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.dump_adv = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/deq_dp.sv */
`default_nettype none

module deq_dp #(
    parameter int CAPACITY = deq_pkg::CAPACITY
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire deq_pkg::deq_cmd_t            cmd,
    output deq_pkg::deq_stat_t                st,
    input  wire logic [deq_pkg::MODE_W-1:0]   in_mode,
    input  wire logic [deq_pkg::DATA_W-1:0]   in_value,
    input  wire logic                         m_tready,
    output logic                              out_valid,
    output logic [deq_pkg::DATA_W-1:0]        out_element,
    output logic                              out_element_valid,
    output logic                              out_last,
    output logic [deq_pkg::STATUS_W-1:0]      out_status,
    output logic [deq_pkg::OCC_W-1:0]         out_occupancy,
    output logic [deq_pkg::SUM_W-1:0]         out_total
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int DW   = deq_pkg::DATA_W;
    localparam int SW   = deq_pkg::SUM_W;
    localparam int OW   = deq_pkg::OCC_W;
    localparam int NMAX = (CAPACITY < deq_pkg::MAX_RESULTS) ? CAPACITY
                                                            : deq_pkg::MAX_RESULTS;
    localparam logic [CW:0]   CAP_EXT  = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [CW-1:0] NMAX_CNT = CW'(NMAX);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    logic [deq_pkg::MODE_W-1:0]   mode_reg;
    logic [DW-1:0]                value_reg;
    logic [IW-1:0]                front_reg, front_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [SW-1:0]                sum_reg, sum_next;
    logic [CW-1:0]                step_reg, step_next;
    logic [CW-1:0]                last_step_reg;
    logic [deq_pkg::STATUS_W-1:0] res_status_reg;

    logic                         out_valid_reg;
    logic [DW-1:0]                out_elem_reg;
    logic                         out_ev_reg;
    logic                         out_last_reg;
    logic [deq_pkg::STATUS_W-1:0] out_status_reg;
    logic [OW-1:0]                out_occ_reg;
    logic [SW-1:0]                out_total_reg;

    logic                         is_push, is_pop, is_dump, full, empty, dir_back;
    logic [CW-1:0]                step_sel, offset, dump_len;
    logic [CW:0]                  pos_ext;
    logic [IW-1:0]                pos, front_dec, front_inc, waddr;
    logic [DW-1:0]                rdata;
    logic [SW-1:0]                sum_pop;
    logic [deq_pkg::STATUS_W-1:0] res_status;

    // Decode the held request
    assign is_push  = (mode_reg == deq_pkg::MODE_PUSH_FRONT) ||
                      (mode_reg == deq_pkg::MODE_PUSH_BACK);
    assign is_pop   = (mode_reg == deq_pkg::MODE_POP_FRONT) ||
                      (mode_reg == deq_pkg::MODE_POP_BACK);
    assign is_dump  = (mode_reg == deq_pkg::MODE_DUMP_FWD) ||
                      (mode_reg == deq_pkg::MODE_DUMP_BWD);
    assign dir_back = (mode_reg == deq_pkg::MODE_POP_BACK) ||
                      (mode_reg == deq_pkg::MODE_DUMP_BWD);
    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);

    always_comb begin
        if (is_push && full) begin
            res_status = deq_pkg::STATUS_FULL;
        end else if ((is_pop || is_dump) && empty) begin
            res_status = deq_pkg::STATUS_EMPTY;
        end else begin
            res_status = deq_pkg::STATUS_OK;
        end
    end

    // Logical offset from the front, then ring position
    assign step_sel = (cmd.pop_rd || cmd.dump_first) ? '0 : step_reg + CW'(1);

    always_comb begin
        if (cmd.push_wr) begin
            offset = count_reg;
        end else if (dir_back) begin
            offset = count_reg - CW'(1) - step_sel;
        end else begin
            offset = step_sel;
        end
    end

    assign pos_ext   = (CW+1)'(front_reg) + (CW+1)'(offset);
    assign pos       = (pos_ext >= CAP_EXT) ? IW'(pos_ext - CAP_EXT) : IW'(pos_ext);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IW'(1);
    assign waddr     = (mode_reg == deq_pkg::MODE_PUSH_FRONT) ? front_dec : pos;
    assign dump_len  = (count_reg > NMAX_CNT) ? NMAX_CNT : count_reg;
    assign sum_pop   = sum_reg - {{(SW-DW){rdata[DW-1]}}, rdata};

    deq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.push_wr),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (cmd.pop_rd || cmd.dump_first || cmd.dump_adv),
        .raddr (pos),
        .rdata (rdata)
    );

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        step_next  = step_reg;
        if (cmd.push_wr) begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + {{(SW-DW){value_reg[DW-1]}}, value_reg};
            if (mode_reg == deq_pkg::MODE_PUSH_FRONT) begin
                front_next = front_dec;
            end
        end
        if (cmd.pop_rd) begin
            count_next = count_reg - CW'(1);
            if (mode_reg == deq_pkg::MODE_POP_FRONT) begin
                front_next = front_inc;
            end
        end
        if (cmd.ld_pop) begin
            sum_next = sum_pop;
        end
        if (cmd.dump_first) begin
            step_next = '0;
        end else if (cmd.dump_adv) begin
            step_next = step_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (cmd.ld_res || cmd.ld_pop || cmd.ld_dump) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        if (cmd.take) begin
            mode_reg  <= in_mode;
            value_reg <= in_value;
        end
        if (cmd.decode) begin
            res_status_reg <= res_status;
        end
        if (cmd.dump_first) begin
            last_step_reg <= dump_len - CW'(1);
        end
        if (cmd.ld_res) begin
            out_elem_reg   <= '0;
            out_ev_reg     <= 1'b0;
            out_last_reg   <= 1'b1;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= OW'(count_reg);
            out_total_reg  <= sum_reg;
        end else if (cmd.ld_pop) begin
            out_elem_reg   <= rdata;
            out_ev_reg     <= 1'b1;
            out_last_reg   <= 1'b1;
            out_status_reg <= deq_pkg::STATUS_OK;
            out_occ_reg    <= OW'(count_reg);
            out_total_reg  <= sum_pop;
        end else if (cmd.ld_dump) begin
            out_elem_reg   <= rdata;
            out_ev_reg     <= 1'b1;
            out_last_reg   <= st.dump_end;
            out_status_reg <= deq_pkg::STATUS_OK;
            out_occ_reg    <= OW'(count_reg);
            out_total_reg  <= sum_reg;
        end
    end

    assign st.is_push  = is_push;
    assign st.is_pop   = is_pop;
    assign st.is_dump  = is_dump;
    assign st.full     = full;
    assign st.empty    = empty;
    assign st.out_free = !out_valid_reg || m_tready;
    assign st.dump_end = (step_reg == last_step_reg);

    assign out_valid         = out_valid_reg;
    assign out_element       = out_elem_reg;
    assign out_element_valid = out_ev_reg;
    assign out_last          = out_last_reg;
    assign out_status        = out_status_reg;
    assign out_occupancy     = out_occ_reg;
    assign out_total         = out_total_reg;

endmodule

`default_nettype wire

/* rtl/double_ended_queue_with_sum.sv */
// Channel   Dir  Signals                    Contents (lowest bit first)
// request   in   s_tvalid/s_tready          s_tuser: mode[2:0]
//                s_tdata[39:0]              value[31:0], zero pad[39:32]
// result    out  m_tvalid/m_tready/m_tlast  m_tuser: element_valid[0], status[2:1]
//                m_tdata[79:0]              element[31:0], occupancy[37:32],
//                                           total[74:38], zero pad[79:75]
//
// Push, rejected push, empty pop or dump and unused modes: each request steps through
// accept, decode and result load. Pop likewise; the popped slot is fetched through
// the registered read port of the slot RAM. Dump of n elements: accept, decode, then one
// element per cycle while m_tready stays high, set by the one slot RAM read port.
// aresetn (synchronous, active low) empties the queue and clears the sum; slot
// contents are not cleared. A stalled result holds in the output register.
`default_nettype none

module double_ended_queue_with_sum #(
    parameter int CAPACITY = deq_pkg::CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // mode[2:0]
    input  wire logic [39:0] s_tdata,   // value[31:0], pad[39:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,
    output logic [2:0]       m_tuser,   // element_valid[0], status[2:1]
    output logic [79:0]      m_tdata    // element[31:0], occupancy[37:32], total[74:38]
);

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_stat_t st;

    logic [deq_pkg::DATA_W-1:0]   element;
    logic                         element_valid;
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::OCC_W-1:0]    occupancy;
    logic [deq_pkg::SUM_W-1:0]    total;

    // Sequence the request: accept, decode, then one or more result loads
    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Ring store, pointers, running sum and the output register
    deq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .st                (st),
        .in_mode           (s_tuser),
        .in_value          (s_tdata[deq_pkg::DATA_W-1:0]),
        .m_tready          (m_tready),
        .out_valid         (m_tvalid),
        .out_element       (element),
        .out_element_valid (element_valid),
        .out_last          (m_tlast),
        .out_status        (status),
        .out_occupancy     (occupancy),
        .out_total         (total)
    );

    // Pack the result fields; pad upper bits with zeros
    assign m_tuser = {status, element_valid};
    assign m_tdata = {5'd0, total, occupancy, element};

endmodule

`default_nettype wire

/* rtl/deq_chk.sv */
`default_nettype none

module deq_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser,
    input wire logic [79:0] m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Error results carry no element and end their request
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:1] != deq_pkg::STATUS_OK) |-> m_tlast && !m_tuser[0])
        else $error("error result without last or with element");

    // Element field is zero unless it carries a stored value
    a_elem_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[31:0] == 32'd0))
        else $error("element nonzero without element_valid");

    // No request is taken while a dump result other than its last is still pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted during a dump");

endmodule

bind double_ended_queue_with_sum deq_chk u_deq_chk (.*);

`default_nettype wire

/* verif/double_ended_queue_with_sum_tb.sv */
`default_nettype none

module double_ended_queue_with_sum_tb;
    import deq_pkg::*;

    // One result as the block reports it on the master side
    typedef struct {
        logic [DATA_W-1:0]   element;
        logic                element_valid;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
        logic [SUM_W-1:0]    total;
    } deque_result_t;

    // Ring-store predictor plus the queue of results still owed by the block
    class deque_scoreboard;
        logic [DATA_W-1:0] slot [CAPACITY];
        int                front;
        int                fill;
        logic [SUM_W-1:0]  sum;
        deque_result_t     owed [$];
        int                errors;

        function new();
            front  = 0;
            fill   = 0;
            sum    = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int outstanding();
            return owed.size();
        endfunction

        function void owe(logic [DATA_W-1:0] element, logic element_valid, logic last,
                          logic [STATUS_W-1:0] status);
            deque_result_t r;
            r.element       = element;
            r.element_valid = element_valid;
            r.last          = last;
            r.status        = status;
            r.occupancy     = OCC_W'(fill);
            r.total         = sum;
            owed.push_back(r);
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
            int pos;
            int n;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (fill == CAPACITY) begin
                        owe('0, 1'b0, 1'b1, STATUS_FULL);
                    end else begin
                        if (mode == MODE_PUSH_FRONT) begin
                            front = (front + CAPACITY - 1) % CAPACITY;
                            pos   = front;
                        end else begin
                            pos = (front + fill) % CAPACITY;
                        end
                        slot[pos] = value;
                        fill++;
                        sum = sum + {{(SUM_W-DATA_W){value[DATA_W-1]}}, value};
                        owe('0, 1'b0, 1'b1, STATUS_OK);
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    if (fill == 0) begin
                        owe('0, 1'b0, 1'b1, STATUS_EMPTY);
                    end else begin
                        if (mode == MODE_POP_FRONT) begin
                            pos   = front;
                            front = (front + 1) % CAPACITY;
                        end else begin
                            pos = (front + fill - 1) % CAPACITY;
                        end
                        fill--;
                        sum = sum - {{(SUM_W-DATA_W){slot[pos][DATA_W-1]}}, slot[pos]};
                        owe(slot[pos], 1'b1, 1'b1, STATUS_OK);
                    end
                end
                MODE_DUMP_FWD, MODE_DUMP_BWD: begin
                    if (fill == 0) begin
                        owe('0, 1'b0, 1'b1, STATUS_EMPTY);
                    end else begin
                        n = (fill < MAX_RESULTS) ? fill : MAX_RESULTS;
                        for (int i = 0; i < n; i++) begin
                            if (mode == MODE_DUMP_FWD)
                                pos = (front + i) % CAPACITY;
                            else
                                pos = (front + fill - 1 - i) % CAPACITY;
                            owe(slot[pos], 1'b1, (i == n - 1), STATUS_OK);
                        end
                    end
                end
                default: begin
                    owe('0, 1'b0, 1'b1, STATUS_OK);
                end
            endcase
        endfunction

        task check_result(logic [2:0] user, logic tlast, logic [79:0] data);
            deque_result_t want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result tdata=%h tuser=%h", data, user));
                return;
            end
            want = owed.pop_front();
            if (data[31:0] !== want.element)
                report($sformatf("element got %h want %h", data[31:0], want.element));
            if (user[0] !== want.element_valid)
                report($sformatf("element_valid got %b want %b", user[0],
                                 want.element_valid));
            if (tlast !== want.last)
                report($sformatf("last got %b want %b", tlast, want.last));
            if (user[2:1] !== want.status)
                report($sformatf("status got %0d want %0d", user[2:1], want.status));
            if (data[37:32] !== want.occupancy)
                report($sformatf("occupancy got %0d want %0d", data[37:32],
                                 want.occupancy));
            if (data[74:38] !== want.total)
                report($sformatf("total got %h want %h", data[74:38], want.total));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser  = '0;   // mode[2:0]
    logic [39:0] s_tdata  = '0;   // value[31:0], pad[39:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tlast;
    logic [2:0]  m_tuser;         // element_valid[0], status[2:1]
    logic [79:0] m_tdata;         // element[31:0], occupancy[37:32], total[74:38]

    // Suppress random idling on both sides while set
    logic            steady = 1'b0;
    deque_scoreboard sb;

    double_ended_queue_with_sum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Stall the result channel at random (chance 36 in 100), except in steady stretches
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 36);
    end

    // Sample both channels at the rising edge: log accepted requests, check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[31:0]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tlast, m_tdata);
        end
    end

    // Present one request, idling at random first; return once it is accepted
    task automatic send_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {8'h00, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the request channel idle until every owed result has arrived
    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    // Push value: signed max/min for style 1/2, else random with extremes mixed in
    function automatic logic [DATA_W-1:0] pick_value(int style);
        case (style)
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: begin
                case ($urandom_range(7))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    initial begin
        bit                growing;
        int                phases;
        int                pick;
        logic [MODE_W-1:0] mode;

        sb = new();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-queue pops and dumps, unused modes, signed extremes
        send_request(MODE_POP_FRONT, 32'h1234_5678);
        send_request(MODE_POP_BACK, 32'h0);
        send_request(MODE_DUMP_FWD, 32'h0);
        send_request(MODE_DUMP_BWD, 32'h0);
        send_request(3'd6, 32'hDEAD_BEEF);
        send_request(3'd7, 32'h0);
        send_request(MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(MODE_PUSH_BACK, 32'h8000_0000);
        send_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(MODE_PUSH_FRONT, 32'h0000_0000);
        send_request(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(MODE_PUSH_BACK, 32'h0000_0001);
        send_request(MODE_DUMP_FWD, 32'h0);
        send_request(MODE_DUMP_BWD, 32'h0);
        send_request(3'd6, 32'h5555_5555);
        send_request(MODE_POP_FRONT, 32'h0);
        send_request(MODE_POP_BACK, 32'h0);
        send_request(MODE_PUSH_FRONT, 32'h8000_0000);
        send_request(MODE_DUMP_FWD, 32'h0);
        send_request(MODE_POP_BACK, 32'h0);
        send_request(MODE_POP_BACK, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        hold_until_drained();

        // Random: alternate fill and drain phases so full and empty both recur
        growing = 1'b1;
        phases  = 0;
        for (int i = 0; i < 180; i++) begin
            steady = (i >= 50 && i < 100);
            if (growing && sb.fill == CAPACITY && $urandom_range(3) == 0) begin
                growing = 1'b0;
                hold_until_drained();
            end else if (!growing && sb.fill == 0 && $urandom_range(3) == 0) begin
                growing = 1'b1;
                phases++;
                hold_until_drained();
            end
            pick = $urandom_range(99);
            if (pick < 8)
                mode = $urandom_range(1) ? MODE_DUMP_BWD : MODE_DUMP_FWD;
            else if (pick < 12)
                mode = $urandom_range(1) ? 3'd7 : 3'd6;
            else if ((pick < 82) == growing)
                mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else
                mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
            send_request(mode, pick_value(phases % 3));
        end
        steady = 1'b0;

        // Drop valid, collect the tail, then watch for stray results
        hold_until_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
